// ===== src/htsed_pkg.sv =====
package htsed_pkg;

  localparam int unsigned WinDepth = 9;
  localparam int unsigned EntReach = 8;
  localparam int unsigned QDepth = 4;

  localparam logic [7:0] ChLt   = 8'h3C;
  localparam logic [7:0] ChGt   = 8'h3E;
  localparam logic [7:0] ChAmp  = 8'h26;
  localparam logic [7:0] ChSemi = 8'h3B;
  localparam logic [7:0] ChHash = 8'h23;
  localparam logic [7:0] ChSp   = 8'h20;
  localparam logic [7:0] ChPlus = 8'h2B;
  localparam logic [7:0] ChMin  = 8'h2D;
  localparam logic [7:0] ChQuot = 8'h22;
  localparam logic [7:0] ChApos = 8'h27;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       text_done;
    logic       no_data;
  } out_item_t;

  function automatic logic is_ws(input logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic is_dig(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

endpackage

// ===== src/htsed_if.sv =====
interface htsed_in_if;
  import htsed_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface htsed_out_if;
  import htsed_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== src/htsed_front.sv =====
module htsed_front
  import htsed_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  htsed_in_if.sink          in_if,
  output logic              q_valid_o,
  output in_item_t          q_data_o,
  input  logic              q_pop_i
);
  localparam int unsigned AW = $clog2(QDepth);

  in_item_t          mem_q [QDepth];
  logic [AW-1:0]     wp_q, rp_q;
  logic [AW:0]       cnt_q;
  logic              push;

  assign in_if.ready = cnt_q != (AW+1)'(QDepth);
  assign push        = in_if.valid && in_if.ready;
  assign q_valid_o   = cnt_q != '0;
  assign q_data_o    = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= in_if.data;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wp_q <= wp_q + 1'b1;
      if (q_pop_i) rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(q_pop_i);
    end
  end
endmodule

// ===== src/htsed_back.sv =====
module htsed_back
  import htsed_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_valid_i,
  input  in_item_t   q_data_i,
  output logic       q_pop_o,
  htsed_out_if.source out_if
);
  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_NUM, S_EMIT, S_DONE
  } state_e;

  state_e       state_q;
  logic [7:0]   win_q [WinDepth];
  logic [3:0]   fill_q;
  logic         tag_q;
  logic         last_q;
  logic [7:0]   hb_q;
  logic         hv_q;
  logic [3:0]   skip_q;
  logic [3:0]   ni_q, nend_q;
  logic [1:0]   nph_q;
  logic         neg_q;
  logic [31:0]  mag_q;
  logic [7:0]   eb_q [3];
  logic [1:0]   ecnt_q, eidx_q;
  logic         ov_q;
  out_item_t    ob_q;

  logic [3:0]   semi;
  logic         named_ok;
  logic [7:0]   named_b;
  logic [3:0]   blen;
  logic [31:0]  code;
  logic [7:0]   c;
  logic         slot;
  logic         pslot;
  logic         prod;
  logic         drop;
  logic         fin;
  logic [7:0]   pbyte;
  logic         ov_set;
  out_item_t    ob_d;

  assign slot = !ov_q || out_if.ready;
  assign pslot = last_q ? (!hv_q || slot) : slot;
  assign out_if.valid = ov_q;
  assign out_if.data  = ob_q;
  assign q_pop_o = state_q == S_IDLE && q_valid_i;
  assign c = win_q[0];

  always_comb begin
    semi = '0;
    for (int p = EntReach; p >= 1; p--) begin
      if (4'(p) < fill_q && win_q[p] == ChSemi) semi = 4'(p);
    end
  end

  always_comb begin
    blen = semi - 4'd1;
    named_ok = 1'b1;
    named_b = ChSp;
    if (blen == 4 && win_q[1] == "n" && win_q[2] == "b" && win_q[3] == "s"
        && win_q[4] == "p") named_b = ChSp;
    else if (blen == 3 && win_q[1] == "a" && win_q[2] == "m" && win_q[3] == "p")
      named_b = ChAmp;
    else if (blen == 2 && win_q[1] == "l" && win_q[2] == "t") named_b = ChLt;
    else if (blen == 2 && win_q[1] == "g" && win_q[2] == "t") named_b = ChGt;
    else if (blen == 4 && win_q[1] == "q" && win_q[2] == "u" && win_q[3] == "o"
             && win_q[4] == "t") named_b = ChQuot;
    else if (blen == 4 && win_q[1] == "a" && win_q[2] == "p" && win_q[3] == "o"
             && win_q[4] == "s") named_b = ChApos;
    else named_ok = 1'b0;
  end

  always_comb begin
    prod = 1'b0;
    drop = 1'b0;
    fin = 1'b0;
    pbyte = c;
    case (state_q)
      S_SCAN: begin
        if (fill_q != 0) begin
          if (skip_q != 0 || c == ChLt || c == ChGt || tag_q) begin
            drop = 1'b1;
          end else if (c != ChAmp) begin
            prod = pslot; drop = pslot;
          end else if (semi != 0) begin
            if (win_q[1] != ChHash && !named_ok) begin
              prod = pslot; drop = pslot; pbyte = ChAmp;
            end
          end else if (fill_q == 4'(WinDepth) || last_q) begin
            prod = pslot; drop = pslot; pbyte = ChAmp;
          end
        end
      end
      S_EMIT: begin
        prod = pslot;
        pbyte = eb_q[eidx_q];
      end
      S_DONE: fin = slot;
      default: ;
    endcase
  end

  always_comb begin
    ov_set = (prod && (!last_q || hv_q)) || fin;
    if (fin && hv_q) ob_d = '{out_byte: hb_q, text_done: 1'b1, no_data: 1'b0};
    else if (fin) ob_d = '{out_byte: 8'h00, text_done: 1'b1, no_data: 1'b1};
    else if (last_q) ob_d = '{out_byte: hb_q, text_done: 1'b0, no_data: 1'b0};
    else ob_d = '{out_byte: pbyte, text_done: 1'b0, no_data: 1'b0};
  end

  assign code = neg_q ? -mag_q : mag_q;

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && q_valid_i) win_q[fill_q] <= q_data_i.in_byte;
    if (drop) begin
      for (int i = 0; i < WinDepth - 1; i++) win_q[i] <= win_q[i+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      fill_q <= '0;
      tag_q <= 1'b0;
      last_q <= 1'b0;
      hb_q <= '0;
      hv_q <= 1'b0;
      skip_q <= '0;
      ov_q <= 1'b0;
      ni_q <= '0; nend_q <= '0; nph_q <= '0; neg_q <= 1'b0; mag_q <= '0;
      ecnt_q <= '0; eidx_q <= '0;
      for (int i = 0; i < 3; i++) eb_q[i] <= '0;
      ob_q <= '0;
    end else begin
      ov_q <= ov_set || (ov_q && !out_if.ready);
      if (ov_set) ob_q <= ob_d;
      if (prod && last_q) begin
        hb_q <= pbyte;
        hv_q <= 1'b1;
      end
      case (state_q)
        S_IDLE: begin
          if (q_valid_i) begin
            fill_q <= fill_q + 4'd1;
            last_q <= q_data_i.end_of_text;
            state_q <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (fill_q == 0) begin
            state_q <= last_q ? S_DONE : S_IDLE;
          end else begin
            if (drop) fill_q <= fill_q - 4'd1;
            if (skip_q != 0) begin
              skip_q <= skip_q - 4'd1;
            end else if (c == ChLt) begin
              tag_q <= 1'b1;
            end else if (c == ChGt) begin
              tag_q <= 1'b0;
            end else if (!tag_q && c == ChAmp) begin
              if (semi != 0) begin
                if (win_q[1] == ChHash) begin
                  ni_q <= 4'd2; nend_q <= semi; nph_q <= '0;
                  neg_q <= 1'b0; mag_q <= '0;
                  state_q <= S_NUM;
                end else if (named_ok) begin
                  eb_q[0] <= named_b; ecnt_q <= 2'd1; eidx_q <= '0;
                  skip_q <= semi + 4'd1;
                  state_q <= S_EMIT;
                end
              end else if (!(fill_q == 4'(WinDepth) || last_q)) begin
                state_q <= S_IDLE;
              end
            end
          end
        end
        S_NUM: begin
          if (ni_q < nend_q && nph_q == 0 && is_ws(win_q[ni_q])) begin
            ni_q <= ni_q + 4'd1;
          end else if (ni_q < nend_q && nph_q == 0
                       && (win_q[ni_q] == ChPlus || win_q[ni_q] == ChMin)) begin
            neg_q <= win_q[ni_q] == ChMin; ni_q <= ni_q + 4'd1; nph_q <= 2'd1;
          end else if (ni_q < nend_q && nph_q != 2'd2 && is_dig(win_q[ni_q])) begin
            mag_q <= mag_q * 32'd10 + 32'(win_q[ni_q] - 8'h30);
            ni_q <= ni_q + 4'd1; nph_q <= 2'd1;
          end else if (nph_q != 2'd2) begin
            nph_q <= 2'd2;
          end else begin
            eidx_q <= '0;
            skip_q <= nend_q + 4'd1;
            state_q <= S_EMIT;
            if (code == 32'd160 || $signed(code) < 32) begin
              eb_q[0] <= ChSp; ecnt_q <= 2'd1;
            end else if ($signed(code) <= 126) begin
              eb_q[0] <= code[7:0]; ecnt_q <= 2'd1;
            end else if (code <= 32'h7FF) begin
              eb_q[0] <= 8'hC0 | 8'(code >> 6);
              eb_q[1] <= 8'h80 | {2'b00, code[5:0]};
              ecnt_q <= 2'd2;
            end else begin
              eb_q[0] <= 8'hE0 | 8'(code >> 12);
              eb_q[1] <= 8'h80 | {2'b00, code[11:6]};
              eb_q[2] <= 8'h80 | {2'b00, code[5:0]};
              ecnt_q <= 2'd3;
            end
          end
        end
        S_EMIT: begin
          if (prod) begin
            eidx_q <= eidx_q + 2'd1;
            if (eidx_q + 2'd1 == ecnt_q) state_q <= S_SCAN;
          end
        end
        S_DONE: begin
          if (fin) begin
            hv_q <= 1'b0;
            fill_q <= '0; tag_q <= 1'b0; skip_q <= '0;
            last_q <= 1'b0;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== src/html_tag_strip_entity_decode.sv =====
// Each accepted item is written into the window, which is then scanned position by
// position; a numeric entity is parsed from its body bytes before its bytes are emitted.
// The core takes one item at a time; a 4-entry input queue absorbs bursts.
// Results of a document's last item are held one deep until the done mark is known,
// then leave one per cycle while the output is not stalled.
// Reset (rst_ni low, asynchronous) empties the queue, window, tag flag and output.
module html_tag_strip_entity_decode
  import htsed_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  htsed_in_if.sink     in_if,
  htsed_out_if.source  out_if
);
  logic     q_valid, q_pop;
  in_item_t q_data;

  htsed_front u_front (
    .clk_i, .rst_ni, .in_if,
    .q_valid_o(q_valid), .q_data_o(q_data), .q_pop_i(q_pop)
  );

  htsed_back u_back (
    .clk_i, .rst_ni,
    .q_valid_i(q_valid), .q_data_i(q_data), .q_pop_o(q_pop), .out_if
  );
endmodule

// ===== src/htsed_checker.sv =====
module htsed_checker
  import htsed_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      out_valid_i,
  input logic      out_ready_i,
  input out_item_t out_data_i
);
  a_nodata_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.no_data |-> out_data_i.text_done)
    else $error("no_data without text_done");
  a_nodata_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.no_data |-> out_data_i.out_byte == 8'h00)
    else $error("no_data with byte");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("output dropped while stalled");
endmodule

bind html_tag_strip_entity_decode htsed_checker u_chk (
  .clk_i, .rst_ni,
  .out_valid_i(out_if.valid), .out_ready_i(out_if.ready), .out_data_i(out_if.data)
);
